>>> rtl/bdlp_pkg.sv
`default_nettype none

package bdlp_pkg;

    localparam int NUM_BUTTONS = 3;

    localparam int ACTION_W = 2;
    localparam int BUTTON_W = 2;
    localparam int PINS_W   = 3;
    localparam int FLAGS_W  = 3;
    localparam int TICKS_W  = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 8;

    localparam logic [TICKS_W-1:0] LONG_TICKS_RESET = TICKS_W'(100);

    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LEVEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS  = 1'b1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK       = 2'd0,
        ACT_TAKE_PRESS = 2'd1,
        ACT_TAKE_LONG  = 2'd2,
        ACT_SW_PRESS   = 2'd3
    } action_t;

    // per-lane controls for one accepted beat
    typedef struct packed {
        logic tick;
        logic pin;
        logic take_press;
        logic take_long;
        logic sw_press;
    } lane_ctrl_t;

    // per-lane state after the beat
    typedef struct packed {
        logic press_flag;
        logic long_flag;
        logic taken;
    } lane_stat_t;

    typedef struct packed {
        logic [FLAGS_W-1:0] long_flags;
        logic [FLAGS_W-1:0] press_flags;
        logic               taken;
    } out_beat_t;

endpackage

`default_nettype wire

>>> rtl/bdlp_lane.sv
`default_nettype none

module bdlp_lane (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire bdlp_pkg::lane_ctrl_t        ctrl,
    input  wire logic                        press_level,
    input  wire logic [bdlp_pkg::TICKS_W-1:0] long_ticks,
    output bdlp_pkg::lane_stat_t             stat
);
    import bdlp_pkg::*;

    typedef enum logic [1:0] {
        MODE_RELEASED = 2'd0,
        MODE_PRESSED  = 2'd1,
        MODE_LONG     = 2'd2
    } mode_t;

    mode_t              mode_reg, mode_next;
    logic               newest_reg, middle_reg, oldest_reg;
    logic               newest_next, middle_next, oldest_next;
    logic [TICKS_W-1:0] hold_reg, hold_next, hold_inc;
    logic               press_reg, press_next;
    logic               long_reg, long_next;
    logic               taken;
    logic               stable;
    logic               is_press;

    always_comb
    begin
        mode_next   = mode_reg;
        newest_next = newest_reg;
        middle_next = middle_reg;
        oldest_next = oldest_reg;
        hold_next   = hold_reg;
        press_next  = press_reg;
        long_next   = long_reg;
        taken       = 1'b0;
        stable      = (middle_reg == newest_reg) && (newest_reg == ctrl.pin);
        is_press    = (ctrl.pin == press_level);
        hold_inc    = (hold_reg == {TICKS_W{1'b1}}) ? hold_reg : hold_reg + 1'b1;

        if (ctrl.tick)
        begin
            oldest_next = middle_reg;
            middle_next = newest_reg;
            newest_next = ctrl.pin;
            if (stable)
            begin
                unique case (mode_reg)
                    MODE_RELEASED:
                    begin
                        if (is_press)
                        begin
                            mode_next  = MODE_PRESSED;
                            press_next = 1'b1;
                        end
                    end
                    MODE_PRESSED:
                    begin
                        if (!is_press)
                        begin
                            mode_next = MODE_RELEASED;
                            hold_next = '0;
                        end
                        else if (hold_inc >= long_ticks)
                        begin
                            mode_next = MODE_LONG;
                            hold_next = '0;
                            long_next = 1'b1;
                        end
                        else
                        begin
                            hold_next = hold_inc;
                        end
                    end
                    MODE_LONG:
                    begin
                        if (!is_press)
                        begin
                            mode_next = MODE_RELEASED;
                        end
                        hold_next = '0;
                    end
                    default:
                    begin
                        mode_next = mode_reg;
                    end
                endcase
            end
        end

        if (ctrl.take_press)
        begin
            taken      = press_reg;
            press_next = 1'b0;
        end
        if (ctrl.take_long)
        begin
            taken     = long_reg;
            long_next = 1'b0;
        end
        if (ctrl.sw_press)
        begin
            press_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_RELEASED;
            newest_reg <= 1'b0;
            middle_reg <= 1'b0;
            oldest_reg <= 1'b0;
            hold_reg   <= '0;
            press_reg  <= 1'b0;
            long_reg   <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            newest_reg <= newest_next;
            middle_reg <= middle_next;
            oldest_reg <= oldest_next;
            hold_reg   <= hold_next;
            press_reg  <= press_next;
            long_reg   <= long_next;
        end
    end

    // oldest sample only feeds the history; stability compares the middle and newest samples with the incoming pin
    logic unused_oldest;
    assign unused_oldest = oldest_reg;

    assign stat.press_flag = press_next;
    assign stat.long_flag  = long_next;
    assign stat.taken      = taken;

endmodule

`default_nettype wire

>>> rtl/bdlp_merge.sv
`default_nettype none

module bdlp_merge (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  push,
    input  wire bdlp_pkg::lane_stat_t [bdlp_pkg::NUM_BUTTONS-1:0] lanes,
    output logic                                       space,
    output logic                                       beat_valid,
    input  wire logic                                  beat_ready,
    output bdlp_pkg::out_beat_t                        beat
);
    import bdlp_pkg::*;

    out_beat_t   merged;
    out_beat_t   buf_mem [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        pop;

    always_comb
    begin
        merged = '0;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            merged.taken = merged.taken | lanes[i].taken;
        end
        for (int i = 0; i < FLAGS_W && i < NUM_BUTTONS; i++)
        begin
            merged.press_flags[i] = lanes[i].press_flag;
            merged.long_flags[i]  = lanes[i].long_flag;
        end
    end

    assign space      = (count_reg != 2'd2);
    assign beat_valid = (count_reg != 2'd0);
    assign pop        = beat_valid && beat_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_mem[wr_ptr_reg] <= merged;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign beat = buf_mem[rd_ptr_reg];

endmodule

`default_nettype wire

>>> rtl/button_debounce_long_press.sv
// Each accepted input beat registers one result beat in the output buffer for m_tvalid.
// Throughput: one beat per cycle while s_tready is high; all button lanes update in parallel.
// A two-beat output buffer keeps s_tready high while one result waits on m_tready.
// Reset (rst_n, async, active low): all buttons released, histories and flags clear,
// press_level 0, long_press_ticks 100, output buffer empty.
`default_nettype none

module button_debounce_long_press (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [1:0] action, [3:2] button, [6:4] pins, [7] zero
    input  wire logic [bdlp_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [0] taken, [3:1] press_flags, [6:4] long_flags, [7] zero
    output logic [bdlp_pkg::OUT_DATA_W-1:0]          m_tdata,
    input  wire logic                                cfg_we,
    input  wire logic [bdlp_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  wire logic [bdlp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import bdlp_pkg::*;

    logic               press_level_reg;
    logic [TICKS_W-1:0] long_ticks_reg;
    logic               accept;
    action_t            action;
    logic [BUTTON_W-1:0] button;
    logic [PINS_W-1:0]  pins;
    lane_ctrl_t [NUM_BUTTONS-1:0] ctrl;
    lane_stat_t [NUM_BUTTONS-1:0] stat;
    out_beat_t          beat;
    logic               unused_pad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_level_reg <= 1'b0;
            long_ticks_reg  <= LONG_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_PRESS_LEVEL: press_level_reg <= cfg_wdata[0];
                CFG_LONG_TICKS:  long_ticks_reg  <= cfg_wdata[TICKS_W-1:0];
                default:         press_level_reg <= press_level_reg;
            endcase
        end
    end

    assign accept     = s_tvalid && s_tready;
    assign action     = action_t'(s_tdata[ACTION_W-1:0]);
    assign button     = s_tdata[ACTION_W +: BUTTON_W];
    assign pins       = s_tdata[ACTION_W+BUTTON_W +: PINS_W];
    assign unused_pad = s_tdata[IN_DATA_W-1];

    for (genvar b = 0; b < NUM_BUTTONS; b++)
    begin : g_lane
        logic sel;
        logic pin;
        if (b < (1 << BUTTON_W))
        begin : g_sel
            assign sel = (button == BUTTON_W'(b));
        end
        else
        begin : g_nosel
            assign sel = 1'b0;
        end
        if (b < PINS_W)
        begin : g_pin
            assign pin = pins[b];
        end
        else
        begin : g_nopin
            assign pin = 1'b0;
        end

        assign ctrl[b].tick       = accept && (action == ACT_TICK);
        assign ctrl[b].pin        = pin;
        assign ctrl[b].take_press = accept && sel && (action == ACT_TAKE_PRESS);
        assign ctrl[b].take_long  = accept && sel && (action == ACT_TAKE_LONG);
        assign ctrl[b].sw_press   = accept && sel && (action == ACT_SW_PRESS);

        bdlp_lane u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl[b]),
            .press_level (press_level_reg),
            .long_ticks  (long_ticks_reg),
            .stat        (stat[b])
        );
    end

    bdlp_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .lanes      (stat),
        .space      (s_tready),
        .beat_valid (m_tvalid),
        .beat_ready (m_tready),
        .beat       (beat)
    );

    assign m_tdata = {1'b0, beat.long_flags, beat.press_flags, beat.taken};

endmodule

`default_nettype wire

>>> rtl/bdlp_checker.sv
`default_nettype none

module bdlp_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic [bdlp_pkg::IN_DATA_W-1:0]  s_tdata,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [bdlp_pkg::OUT_DATA_W-1:0] m_tdata
);
    logic unused_in;
    assign unused_in = ^s_tdata;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output beat changed while stalled");

    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no pending result");

    a_no_invented_beat: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid && !(s_tvalid && s_tready) |=> !m_tvalid)
        else $error("result beat without an accepted input");

endmodule

bind button_debounce_long_press bdlp_checker u_bdlp_checker (.*);

`default_nettype wire

>>> tb/tb_button_debounce_long_press.sv
`timescale 1ns / 100ps

module tb_button_debounce_long_press;

    import bdlp_pkg::*;

    typedef enum logic [1:0]
    {
        MODE_RELEASED = 2'd0,
        MODE_PRESSED  = 2'd1,
        MODE_LONG     = 2'd2
    } btn_mode_t;

    localparam int STALL_LIMIT = 4000;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    // [1:0] action, [3:2] button, [6:4] pins, [7] zero
    logic [IN_DATA_W-1:0]    s_tdata = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    // [0] taken, [3:1] press_flags, [6:4] long_flags, [7] zero
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_addr = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

    // mirror of the debouncer state
    logic                    smp_new [NUM_BUTTONS];
    logic                    smp_mid [NUM_BUTTONS];
    logic                    smp_old [NUM_BUTTONS];
    btn_mode_t               btn_mode [NUM_BUTTONS];
    logic [TICKS_W-1:0]      hold_cnt [NUM_BUTTONS];
    logic [FLAGS_W-1:0]      press_f;
    logic [FLAGS_W-1:0]      long_f;
    logic                    mdl_press_level;
    logic [TICKS_W-1:0]      mdl_long_ticks;

    out_beat_t               expected_flags_q [$];
    int                      err_count = 0;
    int                      idle_cycles = 0;
    bit                      tx_idle_on = 1'b0;
    bit                      rx_idle_on = 1'b0;
    int                      rx_hold_req = 0;
    int                      rx_wait = 0;

    button_debounce_long_press dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    function automatic out_beat_t predict_flags(action_t act, logic [BUTTON_W-1:0] btn,
                                                logic [PINS_W-1:0] pins);
        out_beat_t r;
        logic      lvl;
        r = '0;
        if (act == ACT_TICK)
        begin
            for (int b = 0; b < NUM_BUTTONS; b++)
            begin
                smp_old[b] = smp_mid[b];
                smp_mid[b] = smp_new[b];
                smp_new[b] = pins[b];
                if (smp_old[b] == smp_mid[b] && smp_mid[b] == smp_new[b])
                begin
                    lvl = smp_new[b];
                    case (btn_mode[b])
                        MODE_RELEASED:
                        begin
                            if (lvl == mdl_press_level)
                            begin
                                btn_mode[b] = MODE_PRESSED;
                                press_f[b]  = 1'b1;
                            end
                        end
                        MODE_PRESSED:
                        begin
                            if (lvl != mdl_press_level)
                            begin
                                btn_mode[b] = MODE_RELEASED;
                                hold_cnt[b] = '0;
                            end
                            else
                            begin
                                if (hold_cnt[b] != '1)
                                    hold_cnt[b] = hold_cnt[b] + 1'b1;
                                if (hold_cnt[b] >= mdl_long_ticks)
                                begin
                                    btn_mode[b] = MODE_LONG;
                                    hold_cnt[b] = '0;
                                    long_f[b]   = 1'b1;
                                end
                            end
                        end
                        MODE_LONG:
                        begin
                            if (lvl != mdl_press_level)
                                btn_mode[b] = MODE_RELEASED;
                            hold_cnt[b] = '0;
                        end
                        default: ;
                    endcase
                end
            end
        end
        else if (btn < NUM_BUTTONS)
        begin
            case (act)
                ACT_TAKE_PRESS:
                begin
                    if (press_f[btn])
                    begin
                        press_f[btn] = 1'b0;
                        r.taken = 1'b1;
                    end
                end
                ACT_TAKE_LONG:
                begin
                    if (long_f[btn])
                    begin
                        long_f[btn] = 1'b0;
                        r.taken = 1'b1;
                    end
                end
                default: press_f[btn] = 1'b1;
            endcase
        end
        r.press_flags = press_f;
        r.long_flags  = long_f;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
        err_count++;
    endtask

    task automatic send_beat(action_t act, logic [BUTTON_W-1:0] btn, logic [PINS_W-1:0] pins);
        if (tx_idle_on && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_tdata  <= {1'b0, pins, btn, act};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_flags_q.push_back(predict_flags(act, btn, pins));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_flags_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        drain_results();
        cfg_addr  <= idx;
        cfg_wdata <= val;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_PRESS_LEVEL)
            mdl_press_level = val[0];
        else
            mdl_long_ticks = val;
    endtask

    // default press level 0: the all-zero reset history counts as pressed
    task automatic test_directed();
        repeat (3) send_beat(ACT_TICK, 2'd0, 3'b000);
        for (int b = 0; b < 4; b++)
            send_beat(ACT_TAKE_PRESS, BUTTON_W'(b), 3'b111);
        send_beat(ACT_TAKE_PRESS, 2'd0, 3'b000);
        repeat (3) send_beat(ACT_TICK, 2'd3, 3'b111);
        send_beat(ACT_SW_PRESS, 2'd1, 3'b000);
        send_beat(ACT_SW_PRESS, 2'd3, 3'b111);
        send_beat(ACT_TAKE_LONG, 2'd3, 3'b000);
        send_beat(ACT_TAKE_PRESS, 2'd1, 3'b000);
        // bouncing pins never settle
        send_beat(ACT_TICK, 2'd0, 3'b010);
        send_beat(ACT_TICK, 2'd0, 3'b101);
        send_beat(ACT_TICK, 2'd0, 3'b010);
        send_beat(ACT_TICK, 2'd0, 3'b101);
    endtask

    task automatic test_long_press(logic level, logic [TICKS_W-1:0] ticks, int hold_ticks);
        logic [PINS_W-1:0] down;
        logic [PINS_W-1:0] pins;
        write_reg(CFG_PRESS_LEVEL, CFG_DATA_W'(level));
        write_reg(CFG_LONG_TICKS, ticks);
        down = level ? 3'b111 : 3'b000;
        repeat (4) send_beat(ACT_TICK, 2'd0, ~down);
        repeat (hold_ticks)
        begin
            pins = down;
            if ($urandom_range(0, 3) == 0)
                pins[2] = ~pins[2];
            send_beat(ACT_TICK, BUTTON_W'($urandom_range(0, 3)), pins);
        end
        for (int b = 0; b < 4; b++)
        begin
            send_beat(ACT_TAKE_LONG, BUTTON_W'(b), 3'b000);
            send_beat(ACT_TAKE_PRESS, BUTTON_W'(b), 3'b111);
        end
        repeat (4) send_beat(ACT_TICK, 2'd0, ~down);
    endtask

    // result sink blocked long enough for the output buffer to fill
    task automatic test_backpressure();
        bit keep_idle;
        keep_idle  = tx_idle_on;
        tx_idle_on = 1'b0;
        rx_hold_req = 300;
        repeat (40)
            send_beat(action_t'($urandom_range(0, 3)), BUTTON_W'($urandom_range(0, 3)),
                      PINS_W'($urandom_range(0, 7)));
        tx_idle_on = keep_idle;
    endtask

    task automatic test_random(int n_items);
        logic [PINS_W-1:0] lv;
        logic [PINS_W-1:0] pins;
        lv = PINS_W'($urandom_range(0, 7));
        repeat (n_items)
        begin
            if ($urandom_range(0, 9) < 6)
            begin
                if ($urandom_range(0, 11) == 0)
                    lv[$urandom_range(0, 2)] ^= 1'b1;
                pins = lv;
                if ($urandom_range(0, 7) == 0)
                    pins[$urandom_range(0, 2)] ^= 1'b1;
                send_beat(ACT_TICK, BUTTON_W'($urandom_range(0, 3)), pins);
            end
            else
            begin
                send_beat(action_t'($urandom_range(1, 3)), BUTTON_W'($urandom_range(0, 3)),
                          PINS_W'($urandom_range(0, 7)));
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rx_hold_req > 0)
        begin
            rx_wait = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_wait > 0)
        begin
            m_tready <= 1'b0;
            rx_wait--;
        end
        else if (rx_idle_on && $urandom_range(0, 9) == 0)
        begin
            m_tready <= 1'b0;
            rx_wait = $urandom_range(0, 18);
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        out_beat_t got;
        out_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = out_beat_t'(m_tdata[$bits(out_beat_t)-1:0]);
            if (expected_flags_q.size() == 0)
                report_mismatch("unexpected result beat", got, 0);
            else
            begin
                want = expected_flags_q.pop_front();
                if (got.taken !== want.taken)
                    report_mismatch("taken", got.taken, want.taken);
                if (got.press_flags !== want.press_flags)
                    report_mismatch("press_flags", got.press_flags, want.press_flags);
                if (got.long_flags !== want.long_flags)
                    report_mismatch("long_flags", got.long_flags, want.long_flags);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        foreach (btn_mode[b])
        begin
            smp_new[b]  = 1'b0;
            smp_mid[b]  = 1'b0;
            smp_old[b]  = 1'b0;
            btn_mode[b] = MODE_RELEASED;
            hold_cnt[b] = '0;
        end
        press_f         = '0;
        long_f          = '0;
        mdl_press_level = 1'b0;
        mdl_long_ticks  = LONG_TICKS_RESET;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        test_directed();
        test_long_press(1'b1, 16'd1, 8);
        test_long_press(1'b0, 16'd0, 6);
        test_long_press(1'b1, 16'd3, 10);
        test_long_press(1'b0, 16'd100, 110);
        test_backpressure();
        write_reg(CFG_PRESS_LEVEL, 16'd1);
        write_reg(CFG_LONG_TICKS, 16'd5);
        test_random(200);
        write_reg(CFG_PRESS_LEVEL, 16'd0);
        write_reg(CFG_LONG_TICKS, 16'd2);
        test_random(100);

        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        write_reg(CFG_LONG_TICKS, 16'd7);
        test_random(80);
        test_long_press(1'b1, 16'hFFFF, 6);
        drain_results();

        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> filelist.f
rtl/bdlp_pkg.sv
rtl/bdlp_lane.sv
rtl/bdlp_merge.sv
rtl/button_debounce_long_press.sv
rtl/bdlp_checker.sv
tb/tb_button_debounce_long_press.sv
